// ===== rtl/gpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and default constants of the GPIO port register block.
// Used by every module of the block; depends on nothing.
package gpr_pkg;

    localparam int          NUM_PORTS_DEF    = 7;
    localparam int          PORT_SPAN_DEF    = 4096;
    localparam logic [31:0] BASE_ADDRESS_DEF = 32'hFFFD_9000;

    localparam int          PORTS_REV0   = 5;
    localparam int          PORTS_REV1   = 7;
    localparam logic [2:0]  BUS_SIZE     = 3'd4;

    typedef enum logic [1:0] {
        CMD_BUS_READ  = 2'd0,
        CMD_BUS_WRITE = 2'd1,
        CMD_PIN_SET   = 2'd2,
        CMD_PIN_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PIN_NONE = 2'd0,
        PIN_HIZ  = 2'd1,
        PIN_LOW  = 2'd2,
        PIN_HIGH = 2'd3
    } pin_state_t;

    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_DATA_RD   = 3'd1,
        OP_DATA_WR   = 3'd2,
        OP_DIR_RD    = 3'd3,
        OP_DIR_WR    = 3'd4,
        OP_PIN_SET   = 3'd5,
        OP_PIN_QUERY = 3'd6
    } op_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] address;
        logic [2:0]  access_size;
        logic [31:0] write_data;
        logic [7:0]  pin_number;
        logic        pin_level;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  read_data;
        pin_state_t  pin_state;
        logic [7:0]  changed_pins;
        logic [6:0]  first_pin_of_subport;
        logic [7:0]  previous_latch;
        logic        dirs_changed;
    } out_item_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] bit_sel;
        logic       level;
        logic [7:0] wdata;
    } dec_t;

endpackage
`default_nettype wire

// ===== rtl/gpr_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Address and pin number decoder: turns one input item into an operation and a subport index.
// Depends on gpr_pkg.
module gpr_decode
    import gpr_pkg::*;
#(
    parameter int          NUM_PORTS    = NUM_PORTS_DEF,
    parameter int          PORT_SPAN    = PORT_SPAN_DEF,
    parameter logic [31:0] BASE_ADDRESS = BASE_ADDRESS_DEF,
    localparam int         PW           = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1,
    localparam int         IW           = PW + 1
) (
    input  in_item_t        item,
    input  logic            soc_revision,
    output dec_t            dec,
    output logic [IW-1:0]   idx
);

    localparam int          TOTAL_SPAN = NUM_PORTS * PORT_SPAN;
    localparam int          OFF_W      = $clog2(TOTAL_SPAN);
    localparam logic [31:0] TOTAL_LIM  = 32'(TOTAL_SPAN);
    localparam logic [4:0]  EN_REV0    = 5'((PORTS_REV0 < NUM_PORTS) ? PORTS_REV0 : NUM_PORTS);
    localparam logic [4:0]  EN_REV1    = 5'((PORTS_REV1 < NUM_PORTS) ? PORTS_REV1 : NUM_PORTS);

    logic [31:0]      off;
    logic [OFF_W-1:0] off_lo;
    logic [OFF_W-1:0] base;
    logic [OFF_W-1:0] rem;
    logic [PW-1:0]    q;
    logic [PW-1:0]    port;
    logic [4:0]       en_cnt;
    logic             bus_ok;
    logic             pin_ok;
    logic [IW-1:0]    bus_idx;
    logic [IW-1:0]    pin_idx;

    always_comb begin
        off    = item.address - BASE_ADDRESS;
        off_lo = off[OFF_W-1:0];
        q      = '0;
        base   = '0;
        for (int k = 1; k < NUM_PORTS; k++) begin
            if (off_lo >= OFF_W'(k * PORT_SPAN)) begin
                q    = PW'(k);
                base = OFF_W'(k * PORT_SPAN);
            end
        end
        rem     = off_lo - base;
        port    = PW'(NUM_PORTS - 1) - q;
        en_cnt  = soc_revision ? EN_REV1 : EN_REV0;
        bus_ok  = (item.address[1:0] == 2'b00) && (item.access_size == BUS_SIZE)
                  && (off < TOTAL_LIM) && (5'(port) < en_cnt) && ((rem >> 4) == '0);
        bus_idx = {port, rem[2]};
        pin_ok  = {1'b0, item.pin_number} < {en_cnt, 4'b0000};
        pin_idx = item.pin_number[IW+2:3];
    end

    always_comb begin
        dec.op      = OP_NONE;
        dec.bit_sel = item.pin_number[2:0];
        dec.level   = item.pin_level;
        dec.wdata   = item.write_data[7:0];
        idx         = pin_idx;
        case (item.command)
            CMD_BUS_READ: begin
                idx = bus_idx;
                if (bus_ok) begin
                    dec.op = rem[3] ? OP_DIR_RD : OP_DATA_RD;
                end
            end
            CMD_BUS_WRITE: begin
                idx = bus_idx;
                if (bus_ok) begin
                    dec.op = rem[3] ? OP_DIR_WR : OP_DATA_WR;
                end
            end
            CMD_PIN_SET: begin
                if (pin_ok) begin
                    dec.op = OP_PIN_SET;
                end
            end
            CMD_PIN_QUERY: begin
                if (pin_ok) begin
                    dec.op = OP_PIN_QUERY;
                end
            end
            default: begin
                dec.op = OP_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/gpr_port_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Direction, output latch and input level registers of all subports, with the
// read-modify-write logic that executes one decoded operation. Depends on gpr_pkg.
module gpr_port_regs
    import gpr_pkg::*;
#(
    parameter int  NUM_PORTS = NUM_PORTS_DEF,
    localparam int PW        = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1,
    localparam int IW        = PW + 1,
    localparam int NSUB      = NUM_PORTS * 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          exec_en,
    input  dec_t          dec,
    input  logic [IW-1:0] idx,
    output out_item_t     result
);

    logic [7:0] dir_reg   [NSUB];
    logic [7:0] latch_reg [NSUB];
    logic [7:0] level_reg [NSUB];

    logic [7:0] cur_dir;
    logic [7:0] cur_latch;
    logic [7:0] cur_level;
    logic [7:0] first_pin;

    assign cur_dir   = dir_reg[idx];
    assign cur_latch = latch_reg[idx];
    assign cur_level = level_reg[idx];
    assign first_pin = 8'({idx, 3'b000});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSUB; i++) begin
                dir_reg[i]   <= '0;
                latch_reg[i] <= '0;
                level_reg[i] <= '0;
            end
        end else if (exec_en) begin
            case (dec.op)
                OP_DATA_WR: begin
                    latch_reg[idx] <= dec.wdata;
                end
                OP_DIR_WR: begin
                    dir_reg[idx] <= dec.wdata;
                end
                OP_PIN_SET: begin
                    level_reg[idx][dec.bit_sel] <= dec.level;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        result = '0;
        case (dec.op)
            OP_DATA_RD: begin
                result.ok        = 1'b1;
                result.read_data = (cur_latch & cur_dir) | (cur_level & ~cur_dir);
            end
            OP_DIR_RD: begin
                result.ok        = 1'b1;
                result.read_data = cur_dir;
            end
            OP_DATA_WR: begin
                result.ok                   = 1'b1;
                result.changed_pins         = (cur_latch ^ dec.wdata) & cur_dir;
                result.first_pin_of_subport = first_pin[6:0];
                result.previous_latch       = cur_latch;
            end
            OP_DIR_WR: begin
                result.ok           = 1'b1;
                result.dirs_changed = 1'b1;
            end
            OP_PIN_SET: begin
                result.ok = 1'b1;
            end
            OP_PIN_QUERY: begin
                result.ok = 1'b1;
                if (!cur_dir[dec.bit_sel]) begin
                    result.pin_state = PIN_HIZ;
                end else if (cur_latch[dec.bit_sel]) begin
                    result.pin_state = PIN_HIGH;
                end else begin
                    result.pin_state = PIN_LOW;
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/gpio_port_register_block.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the GPIO port register block: input and result registers, revision register.
// Depends on gpr_pkg, gpr_decode and gpr_port_regs.
//
// Every input transfer produces exactly one result transfer. An item is captured in an
// input register, then decoded and executed combinationally against the subport registers.
// Its result is written to the result register at the end of the cycle in which it executes. The result is
// therefore offered from the result register and is held there until the receiver takes it.
// While results are taken, the block takes one transfer per cycle. The read-modify-write
// of the small per-subport register files, which needs no wait state, sets that rate. If the
// receiver holds a result, the input stalls once the input register is also full.
// The valid, revision and subport registers are cleared by reset directly; no initialization pass is needed.
module gpio_port_register_block
    import gpr_pkg::*;
#(
    parameter int          NUM_PORTS    = NUM_PORTS_DEF,
    parameter int          PORT_SPAN    = PORT_SPAN_DEF,
    parameter logic [31:0] BASE_ADDRESS = BASE_ADDRESS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data
);

    localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int IW = PW + 1;

    in_item_t      in_item_reg;
    logic          in_valid_reg;
    out_item_t     out_item_reg;
    logic          out_valid_reg;
    logic          rev_reg;
    logic          advance;
    dec_t          dec;
    logic [IW-1:0] idx;
    out_item_t     result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    gpr_decode #(
        .NUM_PORTS    (NUM_PORTS),
        .PORT_SPAN    (PORT_SPAN),
        .BASE_ADDRESS (BASE_ADDRESS)
    ) u_decode (
        .item         (in_item_reg),
        .soc_revision (rev_reg),
        .dec          (dec),
        .idx          (idx)
    );

    gpr_port_regs #(
        .NUM_PORTS (NUM_PORTS)
    ) u_port_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec_en (advance),
        .dec     (dec),
        .idx     (idx),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rev_reg       <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                rev_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gpr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker of the GPIO port register block and its bind to the top level.
// Depends on gpr_pkg and gpio_port_register_block.
module gpr_checker
    import gpr_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // A result must not survive reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // A rejected access or pin reports nothing else.
    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.ok |-> m_item.read_data == 8'd0
            && m_item.pin_state == PIN_NONE && m_item.changed_pins == 8'd0
            && m_item.previous_latch == 8'd0 && !m_item.dirs_changed)
        else $error("rejected transfer carries data");

    a_dir_write_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.dirs_changed |-> m_item.ok && m_item.changed_pins == 8'd0
            && m_item.previous_latch == 8'd0 && m_item.pin_state == PIN_NONE)
        else $error("direction write result mixed with other fields");

    // Changed pins are reported only on an accepted data write result.
    a_changed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.changed_pins != 8'd0) |-> m_item.ok && !m_item.dirs_changed)
        else $error("changed pins on a non-write result");

endmodule

bind gpio_port_register_block gpr_checker u_gpr_checker (.*);
`default_nettype wire

// ===== tb/gpio_port_register_block_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gpio_port_register_block: bus accesses and pin items go in,
// and each result transfer is checked against a predictor of the subport registers.
// Depends on gpr_pkg and the gpio_port_register_block RTL.
module gpio_port_register_block_tb;
    import gpr_pkg::*;

    localparam int unsigned NSUB             = NUM_PORTS_DEF * 2;
    localparam logic [31:0] BLOCK_SPAN       = NUM_PORTS_DEF * PORT_SPAN_DEF;
    localparam int unsigned REG_DATA         = 0;
    localparam int unsigned REG_DIR          = 1;
    localparam int unsigned RESET_CYCLES     = 7;
    localparam int unsigned CYCLE_LIMIT      = 1000000;
    localparam int unsigned DRAIN_CYCLES     = 10;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam int unsigned LONG_HOLD_CYCLES = 200;
    localparam int unsigned FIRST_LONG_HOLD  = 200;
    localparam int unsigned SECOND_LONG_HOLD = 700;

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    in_item_t  s_item      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    out_item_t m_item;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      no_idle     = 1'b0;

    in_item_t    pending_items[$];
    out_item_t   expected_results[$];
    logic [7:0]  dir_mirror[NSUB]   = '{default: 8'h00};
    logic [7:0]  latch_mirror[NSUB] = '{default: 8'h00};
    logic [7:0]  level_mirror[NSUB] = '{default: 8'h00};
    logic        revision_mirror    = 1'b0;
    int unsigned send_gap           = 0;
    int unsigned hold_left          = 0;
    int unsigned ready_gap          = 0;
    int unsigned results_checked    = 0;
    int unsigned mismatches         = 0;
    int unsigned cycle_count        = 0;

    gpio_port_register_block DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned enabled_ports(input logic rev);
        int unsigned count;
        count = rev ? PORTS_REV1 : PORTS_REV0;
        return (count > NUM_PORTS_DEF) ? NUM_PORTS_DEF : count;
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 16);
        end
        return $urandom_range(30, 90);
    endfunction

    function automatic logic [31:0] reg_addr(input int unsigned port, input int unsigned sub,
                                             input int unsigned reg_sel);
        return BASE_ADDRESS_DEF + (NUM_PORTS_DEF - 1 - port) * PORT_SPAN_DEF
               + (reg_sel * 2 + sub) * 4;
    endfunction

    function automatic in_item_t bus_item(input cmd_t cmd, input logic [31:0] addr,
                                          input logic [2:0] size, input logic [31:0] data);
        in_item_t it;
        it.command     = cmd;
        it.address     = addr;
        it.access_size = size;
        it.write_data  = data;
        it.pin_number  = 8'($urandom);
        it.pin_level   = 1'($urandom);
        return it;
    endfunction

    function automatic in_item_t pin_item(input cmd_t cmd, input logic [7:0] pin,
                                          input logic level);
        in_item_t it;
        it.command     = cmd;
        it.address     = $urandom;
        it.access_size = 3'($urandom);
        it.write_data  = $urandom;
        it.pin_number  = pin;
        it.pin_level   = level;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned ports;
        int unsigned port;
        int unsigned pick;
        logic [31:0] addr;
        ports = enabled_ports(revision_mirror);
        pick  = $urandom_range(0, 99);
        port  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_PORTS_DEF - 1)
                                            : $urandom_range(0, ports - 1);
        addr  = reg_addr(port, $urandom_range(0, 1), $urandom_range(REG_DATA, REG_DIR));
        if (pick < 40) begin
            it = bus_item(cmd_t'($urandom_range(0, 1)), addr, BUS_SIZE, $urandom);
        end else if (pick < 70) begin
            it = pin_item(cmd_t'($urandom_range(2, 3)),
                          ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, ports * 16 - 1)),
                          1'($urandom));
        end else if (pick < 85) begin
            it = bus_item(cmd_t'($urandom_range(0, 1)), addr, BUS_SIZE, $urandom);
            case ($urandom_range(0, 3))
                0: it.address[1:0] = 2'($urandom_range(1, 3));
                1: it.access_size = 3'($urandom_range(0, 7));
                2: it.address = reg_addr(port, 0, 0) + $urandom_range(4, 1023) * 4;
                default: it.address = $urandom;
            endcase
        end else begin
            it = pin_item(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        end
        return it;
    endfunction

    function automatic out_item_t predict_result(input in_item_t it);
        out_item_t   res;
        logic [31:0] offset;
        logic [31:0] word;
        int unsigned ports;
        int unsigned port;
        int unsigned reg_sel;
        int unsigned idx;
        logic [7:0]  mask;
        res   = '0;
        ports = enabled_ports(revision_mirror);
        if (it.command == CMD_BUS_READ || it.command == CMD_BUS_WRITE) begin
            offset = it.address - BASE_ADDRESS_DEF;
            if (it.address[1:0] == 2'b00 && it.access_size == BUS_SIZE
                    && offset < BLOCK_SPAN) begin
                port    = NUM_PORTS_DEF - 1 - offset / PORT_SPAN_DEF;
                word    = (offset % PORT_SPAN_DEF) / 4;
                reg_sel = word >> 1;
                idx     = port * 2 + word[0];
                if (port < ports && reg_sel <= REG_DIR) begin
                    res.ok = 1'b1;
                    if (reg_sel == REG_DATA && it.command == CMD_BUS_WRITE) begin
                        res.changed_pins         = (latch_mirror[idx] ^ it.write_data[7:0])
                                                   & dir_mirror[idx];
                        res.first_pin_of_subport = 7'(idx * 8);
                        res.previous_latch       = latch_mirror[idx];
                        latch_mirror[idx]        = it.write_data[7:0];
                    end else if (reg_sel == REG_DATA) begin
                        res.read_data = (latch_mirror[idx] & dir_mirror[idx])
                                        | (level_mirror[idx] & ~dir_mirror[idx]);
                    end else if (it.command == CMD_BUS_WRITE) begin
                        dir_mirror[idx]  = it.write_data[7:0];
                        res.dirs_changed = 1'b1;
                    end else begin
                        res.read_data = dir_mirror[idx];
                    end
                end
            end
        end else if (it.pin_number < ports * 16) begin
            idx    = it.pin_number >> 3;
            mask   = 8'h01 << it.pin_number[2:0];
            res.ok = 1'b1;
            if (it.command == CMD_PIN_SET) begin
                level_mirror[idx] = it.pin_level ? (level_mirror[idx] | mask)
                                                 : (level_mirror[idx] & ~mask);
            end else if ((dir_mirror[idx] & mask) == 8'h00) begin
                res.pin_state = PIN_HIZ;
            end else if ((latch_mirror[idx] & mask) != 8'h00) begin
                res.pin_state = PIN_HIGH;
            end else begin
                res.pin_state = PIN_LOW;
            end
        end
        return res;
    endfunction

    task automatic check_result(input out_item_t got);
        out_item_t want;
        string     bad;
        bad = "";
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("Result %0d arrived with nothing expected: %h", results_checked, got);
            end
            return;
        end
        want = expected_results.pop_front();
        if (got.ok !== want.ok) bad = {bad, " ok"};
        if (got.read_data !== want.read_data) bad = {bad, " read_data"};
        if (got.pin_state !== want.pin_state) bad = {bad, " pin_state"};
        if (got.changed_pins !== want.changed_pins) bad = {bad, " changed_pins"};
        if (got.first_pin_of_subport !== want.first_pin_of_subport) bad = {bad, " first_pin"};
        if (got.previous_latch !== want.previous_latch) bad = {bad, " previous_latch"};
        if (got.dirs_changed !== want.dirs_changed) bad = {bad, " dirs_changed"};
        if (bad != "") begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("Result %0d mismatch in%s", results_checked, bad);
                $display("  expected ok=%0d rd=%02h ps=%0d chg=%02h first=%0d prev=%02h dc=%0d",
                         want.ok, want.read_data, want.pin_state, want.changed_pins,
                         want.first_pin_of_subport, want.previous_latch, want.dirs_changed);
                $display("  actual   ok=%0d rd=%02h ps=%0d chg=%02h first=%0d prev=%02h dc=%0d",
                         got.ok, got.read_data, got.pin_state, got.changed_pins,
                         got.first_pin_of_subport, got.previous_latch, got.dirs_changed);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_result(s_item));
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_item   <= pending_items.pop_front();
                    s_valid  <= 1'b1;
                    send_gap <= no_idle ? 0 : draw_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // A long receiver hold at two points lets the block fill up and stall its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_item);
                results_checked++;
            end
            if (m_valid && m_ready && (results_checked == FIRST_LONG_HOLD
                                       || results_checked == SECOND_LONG_HOLD)) begin
                m_ready   <= 1'b0;
                hold_left <= LONG_HOLD_CYCLES;
            end else if (hold_left != 0) begin
                m_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else begin
                ready_gap = no_idle ? 0 : draw_gap();
                m_ready   <= (ready_gap == 0);
                hold_left <= (ready_gap == 0) ? 0 : ready_gap - 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic start_phase(input logic rev, input logic calm);
        @(posedge aclk);
        cfg_wr_en       <= 1'b1;
        cfg_wr_data     <= rev;
        no_idle         <= calm;
        revision_mirror = rev;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic add_random(input int unsigned count);
        repeat (count) pending_items.push_back(random_item());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        pending_items.push_back(bus_item(CMD_BUS_READ, reg_addr(0, 0, REG_DATA), BUS_SIZE, 0));
        pending_items.push_back(bus_item(CMD_BUS_WRITE, reg_addr(0, 0, REG_DIR), BUS_SIZE,
                                         32'hDEAD_BE0F));
        pending_items.push_back(bus_item(CMD_BUS_WRITE, reg_addr(0, 0, REG_DATA), BUS_SIZE,
                                         32'hFFFF_FFA5));
        pending_items.push_back(bus_item(CMD_BUS_WRITE, reg_addr(0, 0, REG_DATA), BUS_SIZE,
                                         32'h0000_00A5));
        pending_items.push_back(pin_item(CMD_PIN_QUERY, 8'd0, 1'b0));
        pending_items.push_back(pin_item(CMD_PIN_QUERY, 8'd1, 1'b0));
        pending_items.push_back(pin_item(CMD_PIN_QUERY, 8'd4, 1'b0));
        pending_items.push_back(pin_item(CMD_PIN_SET, 8'd4, 1'b1));
        pending_items.push_back(bus_item(CMD_BUS_READ, reg_addr(0, 0, REG_DATA), BUS_SIZE, 0));
        pending_items.push_back(bus_item(CMD_BUS_READ, reg_addr(0, 0, REG_DIR), BUS_SIZE, 0));
        pending_items.push_back(bus_item(CMD_BUS_WRITE, reg_addr(4, 1, REG_DATA), BUS_SIZE,
                                         32'hFFFF_FFFF));
        pending_items.push_back(bus_item(CMD_BUS_READ, reg_addr(4, 1, REG_DATA) + 2, BUS_SIZE,
                                         0));
        pending_items.push_back(bus_item(CMD_BUS_READ, reg_addr(0, 0, REG_DATA), 3'd1, 0));
        pending_items.push_back(bus_item(CMD_BUS_WRITE, reg_addr(0, 0, REG_DATA), 3'd7,
                                         32'h0000_005A));
        pending_items.push_back(bus_item(CMD_BUS_READ, BASE_ADDRESS_DEF - 4, BUS_SIZE, 0));
        pending_items.push_back(bus_item(CMD_BUS_READ, BASE_ADDRESS_DEF + BLOCK_SPAN,
                                         BUS_SIZE, 0));
        pending_items.push_back(bus_item(CMD_BUS_READ, 32'h0000_0000, BUS_SIZE, 0));
        pending_items.push_back(bus_item(CMD_BUS_READ, 32'hFFFF_FFFC, BUS_SIZE, 0));
        pending_items.push_back(bus_item(CMD_BUS_READ, reg_addr(5, 0, REG_DATA), BUS_SIZE, 0));
        pending_items.push_back(bus_item(CMD_BUS_WRITE, reg_addr(0, 0, 2), BUS_SIZE, 32'hFF));
        pending_items.push_back(pin_item(CMD_PIN_SET, 8'd80, 1'b1));
        pending_items.push_back(pin_item(CMD_PIN_QUERY, 8'd255, 1'b1));
        pending_items.push_back(pin_item(CMD_PIN_SET, 8'd79, 1'b1));
        pending_items.push_back(pin_item(CMD_PIN_QUERY, 8'd79, 1'b0));
        wait_idle();

        start_phase(1'b1, 1'b0);
        pending_items.push_back(bus_item(CMD_BUS_WRITE, reg_addr(6, 1, REG_DIR), BUS_SIZE,
                                         32'h0000_00FF));
        pending_items.push_back(bus_item(CMD_BUS_WRITE, reg_addr(6, 1, REG_DATA), BUS_SIZE,
                                         32'h0000_0080));
        pending_items.push_back(pin_item(CMD_PIN_QUERY, 8'd111, 1'b0));
        pending_items.push_back(pin_item(CMD_PIN_QUERY, 8'd112, 1'b0));
        pending_items.push_back(pin_item(CMD_PIN_SET, 8'd80, 1'b1));
        pending_items.push_back(bus_item(CMD_BUS_READ, reg_addr(5, 0, REG_DATA), BUS_SIZE, 0));
        wait_idle();

        start_phase(1'b0, 1'b0);
        add_random(300);
        wait_idle();
        start_phase(1'b1, 1'b0);
        add_random(300);
        wait_idle();
        start_phase(1'b1, 1'b1);
        add_random(200);
        wait_idle();
        start_phase(1'b0, 1'b0);
        add_random(400);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
